FILE: rtl/wnv_pkg.sv
package wnv_pkg;

  localparam int unsigned CoordW = 7;
  localparam int unsigned TileW  = 5;
  localparam int unsigned LevelW = 2;
  localparam int unsigned NoiseW = 8;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned DsumW  = 38;
  localparam int unsigned RhsW   = 54;
  localparam int unsigned AccW   = 52;

  // Generator and hash constants.
  localparam logic [31:0] MtInitMul = 32'd1812433253;
  localparam logic [31:0] MtMatrix  = 32'h9908B0DF;
  localparam logic [31:0] HashX     = 32'd19349663;
  localparam logic [31:0] HashY     = 32'd73856093;
  localparam logic [31:0] HashZ     = 32'd83492791;

  // The three draws need state words 1..6 and the taps 397 places further on.
  localparam logic [IdxW-1:0] MtFirst   = 9'd1;
  localparam logic [IdxW-1:0] MtLowLast = 9'd6;
  localparam logic [IdxW-1:0] MtM       = 9'd397;
  localparam logic [IdxW-1:0] MtLast    = 9'd402;

  // 255 squared, the scale of the final root search.
  localparam logic [15:0] RootScale = 16'd65025;
  localparam logic [7:0]  KMax      = 8'd255;

  localparam logic [1:0] DeltaLast = 2'd2;
  localparam logic [1:0] AxisLast  = 2'd2;
  localparam logic [2:0] PhAbs     = 3'd0;
  localparam logic [2:0] PhHiHi    = 3'd1;
  localparam logic [2:0] PhHiLo    = 3'd2;
  localparam logic [2:0] PhLoLo    = 3'd3;
  localparam logic [2:0] PhSum     = 3'd4;

  typedef enum logic [1:0] {
    Tiles4  = 2'd0,
    Tiles8  = 2'd1,
    Tiles16 = 2'd2,
    Tiles32 = 2'd3
  } tile_lvl_e;

  typedef enum logic [3:0] {
    StIdle,
    StSeed,
    StGen,
    StDraw,
    StDist,
    StMin,
    StRootPrep,
    StRoot,
    StDone
  } ctl_state_e;

  typedef struct packed {
    logic            load;
    logic            seed;
    logic            gen;
    logic            draw;
    logic            dist_en;
    logic            min_upd;
    logic            first;
    logic            root_init;
    logic            root_step;
    logic            out_load;
    logic [1:0]      dx;
    logic [1:0]      dy;
    logic [1:0]      dz;
    logic [IdxW-1:0] idx;
    logic [1:0]      axis;
    logic [2:0]      phase;
  } wnv_cmd_t;

  typedef struct packed {
    logic root_done;
  } wnv_stat_t;

  // Standard MT19937 output tempering.
  function automatic logic [31:0] mt_temper(input logic [31:0] v);
    logic [31:0] y;
    y = v;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/wnv_ctrl.sv
module wnv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  wnv_pkg::wnv_stat_t stat_i,
  output wnv_pkg::wnv_cmd_t  cmd_o
);
  import wnv_pkg::*;

  ctl_state_e      state_q, state_d;
  logic [1:0]      dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic [IdxW-1:0] step_q, step_d;
  logic [1:0]      axis_q, axis_d;
  logic [2:0]      ph_q, ph_d;
  logic            oval_q, oval_d;
  logic            last_cell;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dx_q    <= '0;
      dy_q    <= '0;
      dz_q    <= '0;
      step_q  <= '0;
      axis_q  <= '0;
      ph_q    <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      dz_q    <= dz_d;
      step_q  <= step_d;
      axis_q  <= axis_d;
      ph_q    <= ph_d;
      oval_q  <= oval_d;
    end
  end

  assign last_cell   = (dx_q == DeltaLast) && (dy_q == DeltaLast) && (dz_q == DeltaLast);
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = oval_q;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    dz_d    = dz_q;
    step_d  = step_q;
    axis_d  = axis_q;
    ph_d    = ph_q;
    oval_d  = oval_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.dx    = dx_q;
    cmd_o.dy    = dy_q;
    cmd_o.dz    = dz_q;
    cmd_o.idx   = step_q;
    cmd_o.axis  = axis_q;
    cmd_o.phase = ph_q;
    cmd_o.first = (dx_q == 2'd0) && (dy_q == 2'd0) && (dz_q == 2'd0);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          dx_d       = '0;
          dy_d       = '0;
          dz_d       = '0;
          state_d    = StSeed;
        end
      end
      StSeed: begin
        cmd_o.seed = 1'b1;
        step_d     = MtFirst;
        state_d    = StGen;
      end
      StGen: begin
        cmd_o.gen = 1'b1;
        if (step_q == MtLast) begin
          state_d = StDraw;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StDraw: begin
        cmd_o.draw = 1'b1;
        axis_d     = '0;
        ph_d       = PhAbs;
        state_d    = StDist;
      end
      StDist: begin
        cmd_o.dist_en = 1'b1;
        if (ph_q == PhSum) begin
          ph_d = PhAbs;
          if (axis_q == AxisLast) begin
            state_d = StMin;
          end else begin
            axis_d = axis_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      StMin: begin
        cmd_o.min_upd = 1'b1;
        if (last_cell) begin
          state_d = StRootPrep;
        end else begin
          state_d = StSeed;
          if (dz_q != DeltaLast) begin
            dz_d = dz_q + 1'b1;
          end else begin
            dz_d = '0;
            if (dx_q != DeltaLast) begin
              dx_d = dx_q + 1'b1;
            end else begin
              dx_d = '0;
              dy_d = dy_q + 1'b1;
            end
          end
        end
      end
      StRootPrep: begin
        cmd_o.root_init = 1'b1;
        state_d         = StRoot;
      end
      StRoot: begin
        cmd_o.root_step = 1'b1;
        if (stat_i.root_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

FILE: rtl/wnv_datapath.sv
module wnv_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wnv_pkg::LevelW-1:0]    cfg_wdata_i,
  input  logic [wnv_pkg::CoordW-1:0]    vox_x_i,
  input  logic [wnv_pkg::CoordW-1:0]    vox_y_i,
  input  logic [wnv_pkg::CoordW-1:0]    vox_z_i,
  input  wnv_pkg::wnv_cmd_t             cmd_i,
  output wnv_pkg::wnv_stat_t            stat_o,
  output logic [wnv_pkg::NoiseW-1:0]    noise_value_o
);
  import wnv_pkg::*;

  tile_lvl_e          lvl_q;
  logic [TileW-1:0]   tile_q [3];
  logic [31:0]        fq_q   [3];
  logic [31:0]        x_q;
  logic [31:0]        mlo_q  [6];
  logic [31:0]        mhi_q  [3];
  logic [31:0]        u_q    [3];
  logic [33:0]        a_q;
  logic [35:0]        hh_q;
  logic [AccW-1:0]    acc_q;
  logic [DsumW-1:0]   dsum_q;
  logic [DsumW-1:0]   best_q;
  logic [RhsW-1:0]    rhs_q;
  logic [7:0]         k_q;
  logic [17:0]        kk3_q;
  logic [NoiseW-1:0]  res_q;
  logic [NoiseW-1:0]  noise_q;

  logic [CoordW-1:0]  coord [3];
  logic [TileW-1:0]   tile_d [3];
  logic [31:0]        fq_d   [3];
  logic [TileW-1:0]   nmask;
  logic [TileW-1:0]   nb [3];
  logic [1:0]         dsel [3];
  logic [31:0]        seed;
  logic [31:0]        mt_next;
  logic [31:0]        draw [3];
  logic [31:0]        ymix [3];
  logic [1:0]         dcur;
  logic [2:0]         delta;
  logic [34:0]        e_s;
  logic [17:0]        mul_a, mul_b;
  logic [35:0]        prod;
  logic               cond;

  assign coord[0] = vox_x_i;
  assign coord[1] = vox_y_i;
  assign coord[2] = vox_z_i;
  assign dsel[0]  = cmd_i.dx;
  assign dsel[1]  = cmd_i.dy;
  assign dsel[2]  = cmd_i.dz;

  // Cell index and in-cell fraction per axis; the side is 128, so both are bit slices.
  always_comb begin
    nmask = 5'd3;
    for (int a = 0; a < 3; a++) begin
      tile_d[a] = '0;
      fq_d[a]   = '0;
      unique case (lvl_q)
        Tiles4: begin
          tile_d[a] = {3'b000, coord[a][6:5]};
          fq_d[a]   = {coord[a][4:0], 27'b0};
        end
        Tiles8: begin
          tile_d[a] = {2'b00, coord[a][6:4]};
          fq_d[a]   = {coord[a][3:0], 28'b0};
        end
        Tiles16: begin
          tile_d[a] = {1'b0, coord[a][6:3]};
          fq_d[a]   = {coord[a][2:0], 29'b0};
        end
        Tiles32: begin
          tile_d[a] = coord[a][6:2];
          fq_d[a]   = {coord[a][1:0], 30'b0};
        end
        default: begin
          tile_d[a] = '0;
        end
      endcase
    end
    unique case (lvl_q)
      Tiles4:  nmask = 5'd3;
      Tiles8:  nmask = 5'd7;
      Tiles16: nmask = 5'd15;
      Tiles32: nmask = 5'd31;
      default: nmask = 5'd3;
    endcase
  end

  // Wrapped neighbor cell and its hash seed.
  always_comb begin
    logic [5:0] s;
    for (int a = 0; a < 3; a++) begin
      s     = {1'b0, tile_q[a]} + {4'b0, dsel[a]} + 6'd63;
      nb[a] = s[TileW-1:0] & nmask;
    end
    seed = (32'(nb[1]) * HashY) ^ (32'(nb[0]) * HashX) ^ (32'(nb[2]) * HashZ);
  end

  // One seeding step of the generator.
  assign mt_next = MtInitMul * (x_q ^ (x_q >> 30)) + 32'(cmd_i.idx);

  // The three odd draws: twist and temper.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ymix[j] = (mlo_q[2*j] & 32'h80000000) | (mlo_q[2*j+1] & 32'h7FFFFFFF);
      draw[j] = mt_temper(mhi_q[j] ^ (ymix[j] >> 1) ^ (ymix[j][0] ? MtMatrix : 32'd0));
    end
  end

  // Signed displacement on the current axis.
  always_comb begin
    dcur = dsel[cmd_i.axis];
    delta = {1'b0, dcur} - 3'd1;
    e_s = {3'b000, fq_q[cmd_i.axis]} - {delta, 32'b0} - {3'b000, u_q[cmd_i.axis]};
  end

  // Shared 18x18 multiplier for the three partial products of a square.
  always_comb begin
    mul_a = a_q[33:16];
    mul_b = a_q[33:16];
    if (cmd_i.phase == PhHiLo) begin
      mul_b = {2'b00, a_q[15:0]};
    end else if (cmd_i.phase == PhLoLo) begin
      mul_a = {2'b00, a_q[15:0]};
      mul_b = {2'b00, a_q[15:0]};
    end
    prod = mul_a * mul_b;
  end

  assign cond = {4'b0, kk3_q, 32'b0} >= rhs_q;
  assign stat_o.root_done = cond || (k_q == KMax);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= Tiles4;
    end else if (cfg_we_i) begin
      lvl_q <= tile_lvl_e'(cfg_wdata_i);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < 3; a++) begin
        tile_q[a] <= tile_d[a];
        fq_q[a]   <= fq_d[a];
      end
    end
    if (cmd_i.seed) begin
      x_q    <= seed;
      dsum_q <= '0;
    end
    if (cmd_i.gen) begin
      x_q <= mt_next;
      if (cmd_i.idx >= MtFirst && cmd_i.idx <= MtLowLast) begin
        mlo_q[3'(cmd_i.idx[2:0] - 3'd1)] <= mt_next;
      end
      if (cmd_i.idx == MtM + 9'd1) begin
        mhi_q[0] <= mt_next;
      end
      if (cmd_i.idx == MtM + 9'd3) begin
        mhi_q[1] <= mt_next;
      end
      if (cmd_i.idx == MtM + 9'd5) begin
        mhi_q[2] <= mt_next;
      end
    end
    if (cmd_i.draw) begin
      for (int j = 0; j < 3; j++) begin
        u_q[j] <= draw[j];
      end
    end
    if (cmd_i.dist_en) begin
      unique case (cmd_i.phase)
        PhAbs:  a_q    <= e_s[34] ? 34'(-e_s) : e_s[33:0];
        PhHiHi: hh_q   <= prod;
        PhHiLo: acc_q  <= {1'b0, prod[33:0], 17'b0};
        PhLoLo: acc_q  <= acc_q + AccW'(prod);
        PhSum:  dsum_q <= dsum_q + DsumW'(hh_q) + DsumW'(acc_q[AccW-1:32]);
        default: a_q   <= a_q;
      endcase
    end
    if (cmd_i.min_upd && (cmd_i.first || dsum_q < best_q)) begin
      best_q <= dsum_q;
    end
    if (cmd_i.root_init) begin
      rhs_q <= RhsW'(best_q) * RhsW'(RootScale);
      k_q   <= '0;
      kk3_q <= '0;
    end
    if (cmd_i.root_step) begin
      if (cond) begin
        res_q <= KMax - k_q;
      end else if (k_q == KMax) begin
        res_q <= '0;
      end else begin
        k_q   <= k_q + 8'd1;
        kk3_q <= kk3_q + 18'(k_q) * 18'd6 + 18'd3;
      end
    end
    if (cmd_i.out_load) begin
      noise_q <= res_q;
    end
  end

  assign noise_value_o = noise_q;

endmodule

FILE: rtl/worley_noise_voxel.sv
// Sequence: 27 cells, each a hash, the generator seeding steps, a draw, the squared
// distance and a minimum; then the root search and the load of the output register,
// which waits while the previous word is still held and not taken.
// Throughput: one word at a time; a new voxel is accepted only once the previous word
// is in the output register. The pace is set by the single generator seeding multiplier.
// Reset: asynchronous, active low; clears the controller, the output valid and
// tile_level (four cells per axis).
module worley_noise_voxel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wnv_pkg::LevelW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wnv_pkg::CoordW-1:0]    vox_x_i,
  input  logic [wnv_pkg::CoordW-1:0]    vox_y_i,
  input  logic [wnv_pkg::CoordW-1:0]    vox_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wnv_pkg::NoiseW-1:0]    noise_value_o
);
  import wnv_pkg::*;

  wnv_cmd_t  cmd;
  wnv_stat_t stat;

  // Sequencer.
  wnv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  wnv_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .vox_x_i       (vox_x_i),
    .vox_y_i       (vox_y_i),
    .vox_z_i       (vox_z_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .noise_value_o (noise_value_o)
  );

endmodule
